// File: rtl/core/assert_macros.svh
// Assertion shorthands for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define EFP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define EFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/efp_pkg.sv
package efp_pkg;

   // Image geometry and number format
   localparam int IMAGE_WIDTH    = 1024;
   localparam int IMAGE_HEIGHT   = 1024;
   localparam int FRAC_BITS      = 28;
   localparam int ESCAPE_SQUARED = 4;

   // Field widths
   localparam int IDX_W      = 10;
   localparam int COORD_W    = 32;
   localparam int STEP_W     = 31;
   localparam int LIMIT_W    = 12;
   localparam int COLOR_W    = 24;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Pixel to plane mapping: (2*index - size) * step, then halved
   localparam int MAX_SIZE = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
   localparam int DIST_W   = ((IDX_W + 1 > $clog2(MAX_SIZE)) ? IDX_W + 1 : $clog2(MAX_SIZE)) + 1;
   localparam int MAP_W    = DIST_W + STEP_W + 1;

   // Iteration datapath
   localparam int C_W    = COORD_W + 1;
   localparam int PROD_W = 2 * COORD_W;
   localparam int SQ_W   = PROD_W - FRAC_BITS;
   localparam int XY_W   = SQ_W + 1;
   localparam int BND_W  = FRAC_BITS + $clog2(ESCAPE_SQUARED) + 2;
   localparam int ACC_W  = (XY_W + 2 > BND_W) ? XY_W + 2 : BND_W;
   localparam int SAT_W  = (ACC_W > MAP_W) ? ACC_W : MAP_W;

   localparam logic signed [C_W-1:0] MANDEL_SHIFT_RE =
      C_W'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);
   localparam logic signed [C_W-1:0] SHIP_SHIFT_RE =
      C_W'(((64'd1 << FRAC_BITS) + 64'd2) / 64'd5);
   localparam logic signed [C_W-1:0] SHIP_SHIFT_IM =
      C_W'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd2);
   localparam logic signed [ACC_W-1:0] ESC_BOUND =
      ACC_W'(64'(ESCAPE_SQUARED) << FRAC_BITS);

   // Coloring: divisor is limit/20, via a reciprocal multiply
   localparam int COLOR_BANDS  = 20;
   localparam int BAND_W       = $clog2(((2 ** LIMIT_W) - 1) / COLOR_BANDS + 1);
   localparam int RECIP_SHIFT  = LIMIT_W + 4;
   localparam int RECIP        = ((2 ** RECIP_SHIFT) + COLOR_BANDS - 1) / COLOR_BANDS;
   localparam int RECIP_W      = $clog2(RECIP + 1);
   localparam int RECIP_PROD_W = LIMIT_W + RECIP_W;
   localparam int DVD_W        = COLOR_W + LIMIT_W;
   localparam int DIV_CNT_W    = $clog2(DVD_W + 1);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // Fractal kinds; the remaining code runs no iteration
   localparam logic [KIND_W-1:0] KIND_MANDEL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_JULIA  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHIP   = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KIND,
      CSR_STEP,
      CSR_OFS_RE,
      CSR_OFS_IM,
      CSR_JULIA_RE,
      CSR_JULIA_IM,
      CSR_LIMIT,
      CSR_COLOR
   } csr_idx_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [STEP_W-1:0]         step;
      logic signed [COORD_W-1:0] ofs_re;
      logic signed [COORD_W-1:0] ofs_im;
      logic signed [COORD_W-1:0] julia_re;
      logic signed [COORD_W-1:0] julia_im;
      logic [LIMIT_W-1:0]        limit;
      logic [COLOR_W-1:0]        color;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [C_W-1:0]     c_re;
      logic signed [C_W-1:0]     c_im;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
   } job_type;

   typedef struct packed {
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [LIMIT_W-1:0] count;
   } count_type;

   // Saturate a wide signed value to the coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
      logic fits;
      fits = (v[SAT_W-1:COORD_W-1] == {(SAT_W-COORD_W+1){v[SAT_W-1]}});
      if (fits) begin
         return v[COORD_W-1:0];
      end else if (v[SAT_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage

// File: rtl/core/efp_front.sv
module efp_front
   import efp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_push,
   output logic             req_full,
   input  logic [IDX_W-1:0] req_pixel_row,
   input  logic [IDX_W-1:0] req_pixel_col,
   output logic             job_push,
   input  logic             job_full,
   output job_type          job
);

   typedef enum logic [1:0] {ST_IDLE, ST_POINT, ST_JOB} state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          row_ff, row_in, col_ff, col_in;
   logic signed [MAP_W-1:0]   prod_re_ff, prod_re_in, prod_im_ff, prod_im_in;
   logic signed [COORD_W-1:0] pre_ff, pre_in, pim_ff, pim_in;
   logic signed [DIST_W-1:0]  dist_re, dist_im;
   logic signed [STEP_W:0]    step_s;
   logic signed [C_W-1:0]     pre_c, pim_c;

   assign dist_re = $signed({{(DIST_W-IDX_W-1){1'b0}}, req_pixel_col, 1'b0})
                    - DIST_W'(IMAGE_WIDTH);
   assign dist_im = $signed({{(DIST_W-IDX_W-1){1'b0}}, req_pixel_row, 1'b0})
                    - DIST_W'(IMAGE_HEIGHT);
   assign step_s  = $signed({1'b0, cfg.step});
   assign pre_c   = C_W'(pre_ff);
   assign pim_c   = C_W'(pim_ff);

   assign req_full = (state_ff != ST_IDLE);
   assign job_push = (state_ff == ST_JOB) && !job_full;

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      prod_re_in = prod_re_ff;
      prod_im_in = prod_im_ff;
      pre_in     = pre_ff;
      pim_in     = pim_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_push) begin
               row_in     = req_pixel_row;
               col_in     = req_pixel_col;
               prod_re_in = MAP_W'(dist_re) * MAP_W'(step_s);
               prod_im_in = MAP_W'(dist_im) * MAP_W'(step_s);
               state_in   = ST_POINT;
            end
         end
         ST_POINT: begin
            pre_in   = sat_coord(SAT_W'(prod_re_ff >>> 1) + SAT_W'(cfg.ofs_re));
            pim_in   = sat_coord(SAT_W'(prod_im_ff >>> 1) + SAT_W'(cfg.ofs_im));
            state_in = ST_JOB;
         end
         ST_JOB: begin
            if (!job_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Classify by kind: starting z and the constant c
   always_comb begin
      job.kind = cfg.kind;
      job.row  = row_ff;
      job.col  = col_ff;
      job.x0   = '0;
      job.y0   = '0;
      job.c_re = '0;
      job.c_im = '0;
      case (cfg.kind)
         KIND_MANDEL: begin
            job.c_re = pre_c - MANDEL_SHIFT_RE;
            job.c_im = pim_c;
         end
         KIND_JULIA: begin
            job.x0   = pre_ff;
            job.y0   = pim_ff;
            job.c_re = C_W'(cfg.julia_re);
            job.c_im = C_W'(cfg.julia_im);
         end
         KIND_SHIP: begin
            job.c_re = pre_c - SHIP_SHIFT_RE;
            job.c_im = pim_c - SHIP_SHIFT_IM;
         end
         default: begin
            job.c_re = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      row_ff     <= row_in;
      col_ff     <= col_in;
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      pre_ff     <= pre_in;
      pim_ff     <= pim_in;
   end

endmodule

// File: rtl/core/efp_queue.sv
module efp_queue
   import efp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full    = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/core/efp_iter.sv
module efp_iter
   import efp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      job_empty,
   output logic      job_pop,
   input  job_type   job,
   output logic      res_valid,
   input  logic      res_ready,
   output count_type res
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD, ST_DONE} state_type;

   state_type                 state_ff, state_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [C_W-1:0]     cre_ff, cre_in, cim_ff, cim_in;
   logic [IDX_W-1:0]          row_ff, row_in, col_ff, col_in;
   logic [LIMIT_W-1:0]        count_ff, count_in;
   logic signed [SQ_W-1:0]    xx_ff, xx_in, yy_ff, yy_in;
   logic signed [XY_W-1:0]    xy_ff, xy_in;

   logic signed [PROD_W-1:0]  prod_xx, prod_yy, prod_xy;
   logic signed [ACC_W-1:0]   xx_a, yy_a, xy_a, xy_abs, mag, re_sum, im_sum;
   logic                      escaped;

   assign prod_xx = PROD_W'(x_ff) * PROD_W'(x_ff);
   assign prod_yy = PROD_W'(y_ff) * PROD_W'(y_ff);
   assign prod_xy = PROD_W'(x_ff) * PROD_W'(y_ff);

   // Escape test and z update from the registered products
   assign xx_a    = ACC_W'(xx_ff);
   assign yy_a    = ACC_W'(yy_ff);
   assign xy_a    = ACC_W'(xy_ff);
   assign mag     = xx_a + yy_a;
   assign escaped = (mag > ESC_BOUND);
   assign xy_abs  = ((kind_ff == KIND_SHIP) && (xy_a < 0)) ? -xy_a : xy_a;
   assign re_sum  = xx_a - yy_a + ACC_W'(cre_ff);
   assign im_sum  = xy_abs + ACC_W'(cim_ff);

   assign res.row   = row_ff;
   assign res.col   = col_ff;
   assign res.count = count_ff;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      cre_in    = cre_ff;
      cim_in    = cim_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      count_in  = count_ff;
      xx_in     = xx_ff;
      yy_in     = yy_ff;
      xy_in     = xy_ff;
      job_pop   = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               kind_in  = job.kind;
               x_in     = job.x0;
               y_in     = job.y0;
               cre_in   = job.c_re;
               cim_in   = job.c_im;
               row_in   = job.row;
               col_in   = job.col;
               count_in = '0;
               if (job.kind inside {KIND_MANDEL, KIND_JULIA, KIND_SHIP}) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL: begin
            if (count_ff == cfg.limit) begin
               state_in = ST_DONE;
            end else begin
               xx_in    = prod_xx[PROD_W-1:FRAC_BITS];
               yy_in    = prod_yy[PROD_W-1:FRAC_BITS];
               xy_in    = prod_xy[PROD_W-1:FRAC_BITS-1];
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (escaped) begin
               state_in = ST_DONE;
            end else begin
               x_in     = sat_coord(SAT_W'(re_sum));
               y_in     = sat_coord(SAT_W'(im_sum));
               count_in = count_ff + LIMIT_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff  <= kind_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      cre_ff   <= cre_in;
      cim_ff   <= cim_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      count_ff <= count_in;
      xx_ff    <= xx_in;
      yy_ff    <= yy_in;
      xy_ff    <= xy_in;
   end

endmodule

// File: rtl/core/efp_color.sv
module efp_color
   import efp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               res_valid,
   output logic               res_ready,
   input  count_type          res,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [IDX_W-1:0]   rsp_out_row,
   output logic [IDX_W-1:0]   rsp_out_col,
   output logic [COLOR_W-1:0] rsp_pixel_color
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         row_ff, row_in, col_ff, col_in;
   logic [LIMIT_W-1:0]       count_ff, count_in;
   logic                     inside_ff, inside_in;
   logic [DVD_W-1:0]         quo_ff, quo_in;
   logic [BAND_W-1:0]        rem_ff, rem_in, band_ff, band_in;
   logic [DIV_CNT_W-1:0]     step_ff, step_in;
   logic                     out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]         out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic [COLOR_W-1:0]       out_color_ff, out_color_in;

   logic [RECIP_PROD_W-1:0]  recip_prod;
   logic [BAND_W-1:0]        divisor;
   logic [BAND_W:0]          trial;
   logic                     take;

   assign recip_prod = RECIP_PROD_W'(cfg.limit) * RECIP_PROD_W'(RECIP);
   // limit below one band still divides by one
   assign divisor    = (band_ff == '0) ? BAND_W'(1) : band_ff;
   assign trial      = {rem_ff, quo_ff[DVD_W-1]};
   assign take       = (trial >= {1'b0, divisor});

   assign res_ready       = (state_ff == ST_IDLE);
   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_col     = out_col_ff;
   assign rsp_pixel_color = out_color_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      count_in     = count_ff;
      inside_in    = inside_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      band_in      = band_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_color_in = out_color_ff;
      case (state_ff)
         ST_IDLE: begin
            if (res_valid) begin
               row_in    = res.row;
               col_in    = res.col;
               count_in  = res.count;
               inside_in = (res.count >= cfg.limit);
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            quo_in   = inside_ff ? '0 : DVD_W'(cfg.color) * DVD_W'(count_ff);
            band_in  = recip_prod[RECIP_SHIFT +: BAND_W];
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in  = take ? BAND_W'(trial - {1'b0, divisor}) : trial[BAND_W-1:0];
            quo_in  = {quo_ff[DVD_W-2:0], take};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_CNT_W'(DVD_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_row_in   = row_ff;
               out_col_in   = col_ff;
               out_color_in = quo_ff[COLOR_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      count_ff     <= count_in;
      inside_ff    <= inside_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      band_ff      <= band_in;
      step_ff      <= step_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_color_ff <= out_color_in;
   end

endmodule

// File: rtl/core/escape_time_fractal_pixel_core.sv
// Escape-time fractal pixel core (Mandelbrot, Julia, burning ship).
// Input side is a queue write port: an item (pixel row and column) is taken
// when req_push is high and req_full is low. Result side is a queue read
// port: while rsp_empty is low the oldest result (row, column, 24-bit color)
// sits on the rsp_ ports and leaves when rsp_pop is high. One result per item,
// in order. csr_ registers are to be written only while the core is idle; the
// core itself does not enforce this. The front maps the pixel to the plane
// (a registered product, then offset and saturation) and drops a job into a
// 2-entry queue. The back iterates with one shared set of three 32x32
// multipliers: each iteration registers the products, then tests for escape
// and updates z. Coloring then runs a multiply and a 36-step restoring divide.
// The front, iteration engine and coloring unit each hold one item at a time,
// the queue holds two, and all work on different items at once; throughput
// is set by the iteration loop for deep points.
// Reset empties the queue and output register and restores register defaults.
// A stalled receiver keeps the result in the output register; the coloring
// unit, the iteration engine and then the job queue fill up behind it, and
// req_full stays high until space opens up.
`include "assert_macros.svh"

module escape_time_fractal_pixel_core
   import efp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [IDX_W-1:0]      req_pixel_row,
   input  logic [IDX_W-1:0]      req_pixel_col,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [IDX_W-1:0]      rsp_out_row,
   output logic [IDX_W-1:0]      rsp_out_col,
   output logic [COLOR_W-1:0]    rsp_pixel_color,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam cfg_type CFG_RESET = '{
      kind:     KIND_MANDEL,
      step:     STEP_W'(1048576),
      ofs_re:   '0,
      ofs_im:   '0,
      julia_re: '0,
      julia_im: '0,
      limit:    LIMIT_W'(100),
      color:    COLOR_W'(65793)
   };

   cfg_type   cfg_ff, cfg_in;
   logic      job_push, job_full, job_pop, job_empty;
   job_type   front_job, queue_job;
   logic      it_valid, it_ready;
   count_type it_res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KIND:     cfg_in.kind     = csr_wr_data[KIND_W-1:0];
            CSR_STEP:     cfg_in.step     = csr_wr_data[STEP_W-1:0];
            CSR_OFS_RE:   cfg_in.ofs_re   = csr_wr_data[COORD_W-1:0];
            CSR_OFS_IM:   cfg_in.ofs_im   = csr_wr_data[COORD_W-1:0];
            CSR_JULIA_RE: cfg_in.julia_re = csr_wr_data[COORD_W-1:0];
            CSR_JULIA_IM: cfg_in.julia_im = csr_wr_data[COORD_W-1:0];
            CSR_LIMIT:    cfg_in.limit    = csr_wr_data[LIMIT_W-1:0];
            CSR_COLOR:    cfg_in.color    = csr_wr_data[COLOR_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   efp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_pixel_row (req_pixel_row),
      .req_pixel_col (req_pixel_col),
      .job_push      (job_push),
      .job_full      (job_full),
      .job           (front_job)
   );

   efp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (queue_job),
      .empty    (job_empty)
   );

   efp_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job       (queue_job),
      .res_valid (it_valid),
      .res_ready (it_ready),
      .res       (it_res)
   );

   efp_color u_color (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .res_valid       (it_valid),
      .res_ready       (it_ready),
      .res             (it_res),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_pixel_color (rsp_pixel_color)
   );

   // iteration count can never run past the limit
   `EFP_ASSERT_IMPLIES(a_count_bounded, clock, reset, it_valid, it_res.count <= cfg_ff.limit, "iteration count beyond limit")
   // an accepted pixel keeps the front busy for its mapping cycles
   `EFP_ASSERT_NEXT(a_front_busy, clock, reset, req_push && !req_full, req_full, "front took an item while mapping")
   // handing a count to coloring frees the iteration engine
   `EFP_ASSERT_NEXT(a_count_handoff, clock, reset, it_valid && it_ready, !it_valid, "count handed over twice")

endmodule

// File: verif/escape_time_fractal_pixel_core_test.sv
module escape_time_fractal_pixel_core_test;
   import efp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam int     BANDS     = 20;
   // c shifts: -0.3 for mandelbrot, -(0.2, 0.5) for burning ship, rounded to nearest
   localparam longint MANDEL_C_RE = ((longint'(3) <<< FRAC_BITS) + 5) / 10;
   localparam longint SHIP_C_RE   = ((longint'(1) <<< FRAC_BITS) + 2) / 5;
   localparam longint SHIP_C_IM   = ((longint'(1) <<< FRAC_BITS) + 1) / 2;
   localparam int     RANDOM_SETUPS = 30;
   localparam int     PIXELS_PER_SETUP = 31;

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } pixel_type;

   typedef struct packed {
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [COLOR_W-1:0] color;
   } shade_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [IDX_W-1:0]      req_pixel_row = '0;
   logic [IDX_W-1:0]      req_pixel_col = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [IDX_W-1:0]      rsp_out_row;
   logic [IDX_W-1:0]      rsp_out_col;
   logic [COLOR_W-1:0]    rsp_pixel_color;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // register shadow, starts at the reset values
   logic [KIND_W-1:0] kind_now = KIND_MANDEL;
   longint            step_now = 1048576;
   longint            ofs_re_now = 0;
   longint            ofs_im_now = 0;
   longint            julia_re_now = 0;
   longint            julia_im_now = 0;
   int unsigned       limit_now = 100;
   int unsigned       color_now = 65793;

   pixel_type pixels_waiting[$];
   shade_type shades_due[$];
   int     send_gap_pct = 0;
   int     recv_gap_pct = 0;
   int     hold_cycles = 0;
   int     failures = 0;
   int     n_sent = 0;
   int     n_colored = 0;
   int     n_black = 0;
   int     n_setups = 1;

   escape_time_fractal_pixel_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_pixel_row   (req_pixel_row),
      .req_pixel_col   (req_pixel_col),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_pixel_color (rsp_pixel_color),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint sat_coord32(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // (2*index - size) * step, halved with floor, plus the view offset
   function automatic longint plane_point(int idx, int size, longint ofs);
      longint d;
      d = 2 * longint'(idx) - size;
      return sat_coord32(((d * step_now) >>> 1) + ofs);
   endfunction

   function automatic int unsigned escape_count(longint pre, longint pim);
      longint      x, y, cre, cim, xx, yy, xy2, bound;
      int unsigned n;
      bound = longint'(ESCAPE_SQUARED) <<< FRAC_BITS;
      n = 0;
      if (kind_now == KIND_JULIA) begin
         x = pre; y = pim; cre = julia_re_now; cim = julia_im_now;
      end else if (kind_now == KIND_SHIP) begin
         x = 0; y = 0; cre = pre - SHIP_C_RE; cim = pim - SHIP_C_IM;
      end else if (kind_now == KIND_MANDEL) begin
         x = 0; y = 0; cre = pre - MANDEL_C_RE; cim = pim;
      end else begin
         return 0;
      end
      // escape test comes before each step, so an escaped start point counts 0
      while (n < limit_now) begin
         xx  = (x * x) >>> FRAC_BITS;
         yy  = (y * y) >>> FRAC_BITS;
         xy2 = (x * y) >>> (FRAC_BITS - 1);
         if (xx + yy > bound) break;
         if (kind_now == KIND_SHIP && xy2 < 0) xy2 = -xy2;
         x = sat_coord32(xx - yy + cre);
         y = sat_coord32(xy2 + cim);
         n++;
      end
      return n;
   endfunction

   function automatic shade_type shade_pixel(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
      shade_type   s;
      longint      div;
      int unsigned n;
      n = escape_count(plane_point(int'(col), IMAGE_WIDTH, ofs_re_now),
                       plane_point(int'(row), IMAGE_HEIGHT, ofs_im_now));
      s.row   = row;
      s.col   = col;
      s.color = '0;
      if (n < limit_now) begin
         div = limit_now / BANDS;
         if (div == 0) div = 1;
         s.color = COLOR_W'((longint'(color_now) * n) / div);
      end
      return s;
   endfunction

   // driver: one NBA per signal per edge, item held while full
   always @(posedge clock) begin
      pixel_type next_px;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            shades_due.push_back(shade_pixel(req_pixel_row, req_pixel_col));
            n_sent++;
         end
         if (!req_push || !req_full) begin
            if (pixels_waiting.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               next_px = pixels_waiting.pop_front();
               req_push      <= 1'b1;
               req_pixel_row <= next_px.row;
               req_pixel_col <= next_px.col;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      shade_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (shades_due.size() == 0) begin
               $error("unexpected item: row %0d col %0d color %06h",
                      rsp_out_row, rsp_out_col, rsp_pixel_color);
               failures++;
            end else begin
               want = shades_due.pop_front();
               if (rsp_out_row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
                  failures++;
               end
               if (rsp_out_col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
                  failures++;
               end
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color: expected %06h, got %06h (row %0d col %0d)",
                         want.color, rsp_pixel_color, want.row, want.col);
                  failures++;
               end
               if (want.color == 0) n_black++;
               else n_colored++;
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
   end

   task automatic set_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         CSR_KIND:     kind_now     = val[KIND_W-1:0];
         CSR_STEP:     step_now     = longint'(val[STEP_W-1:0]);
         CSR_OFS_RE:   ofs_re_now   = longint'($signed(val));
         CSR_OFS_IM:   ofs_im_now   = longint'($signed(val));
         CSR_JULIA_RE: julia_re_now = longint'($signed(val));
         CSR_JULIA_IM: julia_im_now = longint'($signed(val));
         CSR_LIMIT:    limit_now    = val[LIMIT_W-1:0];
         CSR_COLOR:    color_now    = val[COLOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_setup(input logic [KIND_W-1:0] kind, input logic [STEP_W-1:0] step,
                             input logic [COORD_W-1:0] ore, input logic [COORD_W-1:0] oim,
                             input logic [COORD_W-1:0] jre, input logic [COORD_W-1:0] jim,
                             input logic [LIMIT_W-1:0] lim, input logic [COLOR_W-1:0] color);
      set_reg(CSR_KIND, CSR_DATA_W'(kind));
      set_reg(CSR_STEP, CSR_DATA_W'(step));
      set_reg(CSR_OFS_RE, ore);
      set_reg(CSR_OFS_IM, oim);
      set_reg(CSR_JULIA_RE, jre);
      set_reg(CSR_JULIA_IM, jim);
      set_reg(CSR_LIMIT, CSR_DATA_W'(lim));
      set_reg(CSR_COLOR, CSR_DATA_W'(color));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      n_setups++;
   endtask

   task automatic load_random_setup();
      logic [KIND_W-1:0]  kind;
      logic [STEP_W-1:0]  step;
      logic [COORD_W-1:0] ore, oim, jre, jim;
      logic [LIMIT_W-1:0] lim;
      int                 pick;
      pick = $urandom_range(0, 9);
      kind = (pick < 3) ? KIND_MANDEL : (pick < 6) ? KIND_JULIA :
             (pick < 9) ? KIND_SHIP : KIND_NONE;
      if ($urandom_range(0, 7) == 0) begin
         step = STEP_W'($urandom);
         ore  = $urandom;
         oim  = $urandom;
      end else begin
         // views between full image and strong zoom, centered within +-2
         step = STEP_W'($urandom_range(1 << 12, 1 << 21));
         ore  = $urandom_range(0, 1 << 30) - (1 << 29);
         oim  = $urandom_range(0, 1 << 30) - (1 << 29);
      end
      if ($urandom_range(0, 7) == 0) begin
         jre = $urandom;
         jim = $urandom;
      end else begin
         jre = $urandom_range(0, 1 << 29) - (1 << 28);
         jim = $urandom_range(0, 1 << 29) - (1 << 28);
      end
      lim = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom_range(0, BANDS - 1)) :
                                          LIMIT_W'($urandom_range(BANDS, 120));
      load_setup(kind, step, ore, oim, jre, jim, lim,
                 COLOR_W'($urandom_range(0, 24'hFFFFFF)));
   endtask

   task automatic queue_pixel(input int row, input int col);
      pixel_type px;
      px.row = IDX_W'(row);
      px.col = IDX_W'(col);
      pixels_waiting.push_back(px);
   endtask

   task automatic queue_random_pixels(input int count);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            queue_pixel($urandom_range(448, 575), $urandom_range(448, 575));
         else
            queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
   endtask

   // sender holds off until every pixel is back
   task automatic wait_idle();
      @(negedge clock);
      while (pixels_waiting.size() != 0 || req_push || shades_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      send_gap_pct = 26;
      recv_gap_pct = 84;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: the four corners, center (inside, black), one inner point
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(512, 512);
      queue_pixel(0, 1023);
      queue_pixel(1023, 0);
      queue_pixel(256, 700);
      wait_idle();

      // saturated mapping, julia start already outside
      load_setup(KIND_JULIA, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 12'hFFF, 24'hFF_FFFF);
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(512, 512);
      wait_idle();

      // burning ship at the deepest limit
      load_setup(KIND_SHIP, 31'd1 << 20, '0, '0, '0, '0, 12'hFFF, 24'hFF_FFFF);
      queue_pixel(512, 512);
      queue_pixel(400, 600);
      queue_pixel(700, 300);
      wait_idle();

      // julia, c = -0.8 + 0.156i
      load_setup(KIND_JULIA, 31'd1 << 20, '0, '0, -32'sd214748365, 32'sd41875931,
                 12'd60, 24'h12_3456);
      queue_pixel(512, 512);
      queue_pixel(300, 800);
      queue_pixel(600, 450);
      wait_idle();

      // unused kind with zero limit
      load_setup(KIND_NONE, 31'd1 << 20, '0, '0, '0, '0, 12'd0, 24'hFF_FFFF);
      queue_pixel(512, 512);
      queue_pixel(5, 9);
      wait_idle();

      // step zero, limit below one band: divisor forced to one
      load_setup(KIND_MANDEL, '0, 32'hF800_0000, 32'h1000_0000, '0, '0, 12'd1, 24'hAB_CDEF);
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      wait_idle();

      // zero limit, no step runs
      load_setup(KIND_MANDEL, 31'd1 << 20, '0, '0, '0, '0, 12'd0, 24'hFF_FFFF);
      queue_pixel(512, 512);
      queue_pixel(0, 0);
      wait_idle();

      load_setup(KIND_SHIP, 31'd1 << 22, '0, '0, '0, '0, 12'd19, 24'h80_0001);
      queue_pixel(100, 900);
      queue_pixel(900, 100);
      wait_idle();

      for (int ph = 0; ph < RANDOM_SETUPS; ph++) begin
         if (ph == RANDOM_SETUPS / 3) begin
            send_gap_pct = 84;
            recv_gap_pct = 26;
         end
         if (ph == 2 * RANDOM_SETUPS / 3) begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         load_random_setup();
         queue_random_pixels(PIXELS_PER_SETUP);
         // long receiver stall while the sender keeps pushing
         if (ph == 2 * RANDOM_SETUPS / 3) hold_cycles = 2000;
         wait_idle();
      end

      repeat (100) @(posedge clock);
      $display("%0d pixels under %0d register settings (all kinds, limits 0 to 4095)",
               n_sent, n_setups);
      $display("%0d colored and %0d black results checked", n_colored, n_black);
      if (failures == 0 && shades_due.size() == 0) begin
         $display("escape_time_fractal_pixel_core_test OK");
      end else begin
         $display("escape_time_fractal_pixel_core_test NOT OK");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout: %0d pixels sent, %0d results outstanding", n_sent, shades_due.size());
      $display("escape_time_fractal_pixel_core_test NOT OK");
      $finish;
   end

endmodule
